// File: design/tmcc_fs_pkg.sv
// Shared types and constants of the TMCC DBPSK frame synchronizer.
package tmcc_fs_pkg;

    // Sample format and pilot store size.
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_PILOTS  = 52;
    localparam int PILOT_IDX_W = 6;
    localparam int CFG_W       = 6;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd13;

    // Vote accumulator holds a signed count of at most MAX_PILOTS votes.
    localparam int VOTE_W = 7;

    // Bit window and sync word.
    localparam int WINDOW_BITS = 204;
    localparam int SYNC_LEN    = 16;
    localparam int SINCE_W     = 8;
    localparam logic [SINCE_W-1:0] CHECK_GAP = 8'd203;

    // Shortened BCH(273,191) parity check.
    localparam int CODE_N      = 273;
    localparam int CODE_K      = 191;
    localparam int ZERO_PAD    = 89;
    localparam int INFO_START  = 20;
    localparam int PARITY_ROWS = CODE_N - CODE_K;
    localparam int ROW_W       = 7;
    localparam int WEIGHT_W    = 7;

    // Sync words, index 0 is the first (oldest) window bit compared.
    localparam logic [0:SYNC_LEN-1] SYNC_EVEN = 16'b0011010111101110;
    localparam logic [0:SYNC_LEN-1] SYNC_ODD  = 16'b1100101000010001;

    // Check row of the parity matrix, index 0 is the leftmost bit.
    localparam logic [0:CODE_K] CHECK_ROW = {
        24'b100010001010100010000010,
        24'b100010000010000000001010,
        24'b100010100000001010111011,
        24'b000111110011010010000101,
        24'b011101110010111110100001,
        24'b111101011010011100011000,
        24'b010000100011001010100101,
        24'b111101100001110001100001
    };

    // One pilot sample beat.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_re;
        logic signed [SAMPLE_BITS-1:0] sample_im;
    } t_sample;

    // One symbol result beat.
    typedef struct packed {
        logic                tmcc_bit;
        logic                sync_match;
        logic [WEIGHT_W-1:0] syndrome_weight;
        logic                frame_end;
    } t_result;

    // Control sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_VOTE,
        S_CHECK,
        S_SYND,
        S_EMIT
    } t_state;

endpackage

// File: design/tmcc_dbpsk_frame_sync_core.sv
// TMCC DBPSK symbol decision and frame synchronizer with serial BCH parity check.
module tmcc_dbpsk_frame_sync_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [tmcc_fs_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  tmcc_fs_pkg::t_sample           i_sample,
    output logic                           o_valid,
    input  logic                           i_stall,
    output tmcc_fs_pkg::t_result           o_result
);
    // Each pilot beat is compared with the same carrier's sample from the
    // previous symbol, and the sign of the real part of the product is voted
    // over the symbol. A pilot beat that does not close a symbol passes through
    // the pilot store read, the two 16x16 multiplies and the vote. The beat that
    // closes a symbol also passes through the sync compare and the result register.
    // When the check window is open and the sync word matches, the parity
    // syndrome is walked one row per cycle through a 273-bit shift register
    // before that beat's result is registered. The pilot store has a valid bit per
    // entry, so no clearing pass follows reset. One result beat is produced per
    // symbol; a result may wait in the output register while the next pilot
    // beat is taken.
    import tmcc_fs_pkg::*;

    // Control state.
    t_state                   r_state, n_state;
    logic [CFG_W-1:0]         r_cfg;
    logic [PILOT_IDX_W-1:0]   r_count;
    logic signed [VOTE_W-1:0] r_vote;
    logic [SINCE_W-1:0]       r_since;
    logic [0:WINDOW_BITS-1]   r_window;
    logic [MAX_PILOTS-1:0]    r_pilot_vld;
    logic [ROW_W-1:0]         r_row;
    logic                     r_out_valid;

    // Payload registers.
    logic signed [SAMPLE_BITS-1:0]   r_re, r_im;
    logic [PILOT_IDX_W-1:0]          r_idx;
    logic                            r_idx_ok;
    logic [2*SAMPLE_BITS-1:0]        r_rd_data;
    logic                            r_rd_vld;
    logic signed [2*SAMPLE_BITS-1:0] r_prod_re, r_prod_im;
    logic                            r_bit;
    logic                            r_match;
    logic                            r_fend;
    logic [WEIGHT_W-1:0]             r_weight;
    logic [0:CODE_N-1]               r_code;
    t_result                         r_result;

    // Pilot store.
    logic [2*SAMPLE_BITS-1:0] r_pilot_mem [MAX_PILOTS];

    // Decoded controls.
    logic w_accept;
    logic w_do_mul;
    logic w_do_vote;
    logic w_do_check;
    logic w_do_synd;
    logic w_do_emit;
    logic w_out_free;

    // Datapath intermediates.
    logic signed [SAMPLE_BITS-1:0] w_prev_re, w_prev_im;
    logic [2*SAMPLE_BITS:0]        w_real;
    logic signed [VOTE_W-1:0]      n_vote;
    logic [PILOT_IDX_W-1:0]        n_count;
    logic [PILOT_IDX_W-1:0]        w_eff;
    logic                          w_close;
    logic                          w_sync_hit;
    logic                          w_row_par;
    logic [WEIGHT_W-1:0]           n_weight;
    logic                          w_last_row;
    logic [SINCE_W-1:0]            n_since_inc;

    assign w_out_free = !r_out_valid || !i_stall;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_VOTE;
            end
            S_VOTE: begin
                n_state = w_close ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                n_state = w_sync_hit ? S_SYND : S_EMIT;
            end
            S_SYND: begin
                if (w_last_row) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_stall    = 1'b1;
        w_do_mul   = 1'b0;
        w_do_vote  = 1'b0;
        w_do_check = 1'b0;
        w_do_synd  = 1'b0;
        w_do_emit  = 1'b0;
        case (r_state)
            S_IDLE:  o_stall    = !i_rst_n;
            S_MUL:   w_do_mul   = 1'b1;
            S_VOTE:  w_do_vote  = 1'b1;
            S_CHECK: w_do_check = 1'b1;
            S_SYND:  w_do_synd  = 1'b1;
            S_EMIT:  w_do_emit  = w_out_free;
            default: o_stall    = 1'b1;
        endcase
    end

    assign w_accept = i_valid && !o_stall;

    // Previous pilot, zero where the carrier has not been seen yet.
    assign w_prev_re = r_rd_vld ? r_rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
    assign w_prev_im = r_rd_vld ? r_rd_data[SAMPLE_BITS-1:0] : '0;

    // Real part of x * conj(prev); only its sign is used.
    assign w_real = {r_prod_re[2*SAMPLE_BITS-1], r_prod_re}
                  + {r_prod_im[2*SAMPLE_BITS-1], r_prod_im};

    // Vote update and symbol close decision.
    always_comb begin
        n_vote = r_vote;
        if (r_idx_ok) begin
            n_vote = w_real[2*SAMPLE_BITS] ? r_vote - VOTE_W'(1) : r_vote + VOTE_W'(1);
        end
        n_count = r_idx + PILOT_IDX_W'(1);
        if (r_cfg == '0) begin
            w_eff = PILOT_IDX_W'(1);
        end else if (r_cfg > CFG_W'(MAX_PILOTS)) begin
            w_eff = PILOT_IDX_W'(MAX_PILOTS);
        end else begin
            w_eff = r_cfg;
        end
        w_close = (n_count == '0) || (n_count >= w_eff);
    end

    // Sync compare on the freshly shifted window.
    assign w_sync_hit = (r_since >= CHECK_GAP)
                     && ((r_window[1:SYNC_LEN] == SYNC_EVEN)
                      || (r_window[1:SYNC_LEN] == SYNC_ODD));

    // One parity row per cycle over the code shift register.
    assign w_row_par   = ^(CHECK_ROW & r_code[0:CODE_K]);
    assign n_weight    = r_weight + WEIGHT_W'(w_row_par);
    assign w_last_row  = (r_row == ROW_W'(PARITY_ROWS - 1));
    assign n_since_inc = (r_since < CHECK_GAP) ? r_since + SINCE_W'(1) : r_since;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET;
            r_count     <= '0;
            r_vote      <= '0;
            r_since     <= CHECK_GAP;
            r_window    <= '0;
            r_pilot_vld <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (w_do_mul && r_idx_ok) begin
                r_pilot_vld[r_idx] <= 1'b1;
            end
            if (w_do_vote) begin
                if (w_close) begin
                    r_count  <= '0;
                    r_vote   <= '0;
                    r_window <= {r_window[1:WINDOW_BITS-1], n_vote[VOTE_W-1]};
                end else begin
                    r_count <= n_count;
                    r_vote  <= n_vote;
                end
            end
            if (w_do_check) begin
                r_row <= '0;
                if (!w_sync_hit) begin
                    r_since <= n_since_inc;
                end
            end
            if (w_do_synd) begin
                r_row <= r_row + ROW_W'(1);
                if (w_last_row) begin
                    r_since <= (n_weight == '0) ? '0 : n_since_inc;
                end
            end
            if (w_do_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pilot store: read on accept, write back the new sample in the cycle after.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_data <= r_pilot_mem[r_count];
        end
        if (w_do_mul && r_idx_ok) begin
            r_pilot_mem[r_idx] <= {r_re, r_im};
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_re     <= i_sample.sample_re;
            r_im     <= i_sample.sample_im;
            r_idx    <= r_count;
            r_idx_ok <= (r_count < PILOT_IDX_W'(MAX_PILOTS));
            r_rd_vld <= (r_count < PILOT_IDX_W'(MAX_PILOTS)) && r_pilot_vld[r_count];
        end
        if (w_do_mul) begin
            r_prod_re <= r_re * w_prev_re;
            r_prod_im <= r_im * w_prev_im;
        end
        if (w_do_vote && w_close) begin
            r_bit <= n_vote[VOTE_W-1];
        end
        if (w_do_check) begin
            r_match  <= w_sync_hit;
            r_weight <= '0;
            r_fend   <= 1'b0;
            r_code   <= {ZERO_PAD'(0), r_window[INFO_START:WINDOW_BITS-1]};
        end
        if (w_do_synd) begin
            r_weight <= n_weight;
            r_code   <= {r_code[1:CODE_N-1], 1'b0};
            if (w_last_row) begin
                r_fend <= (n_weight == '0);
            end
        end
        if (w_do_emit) begin
            r_result.tmcc_bit        <= r_bit;
            r_result.sync_match      <= r_match;
            r_result.syndrome_weight <= r_weight;
            r_result.frame_end       <= r_fend;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

`ifndef SYNTHESIS
    // The carrier counter never passes the pilot store between symbols.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_count < PILOT_IDX_W'(MAX_PILOTS))
        else $error("carrier counter beyond pilot store");

    // The vote sum stays within one vote per pilot.
    a_vote_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vote <= VOTE_W'(MAX_PILOTS)) && (r_vote >= -VOTE_W'(MAX_PILOTS)))
        else $error("vote sum out of range");

    // A frame end is only reported with a sync match and a clean syndrome.
    a_fend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.frame_end |->
            o_result.sync_match && (o_result.syndrome_weight == '0))
        else $error("frame end without clean parity");

    // The syndrome walk always ends after the last parity row.
    a_synd_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SYND && w_last_row |=> r_state == S_EMIT)
        else $error("syndrome walk overran");
`endif

endmodule
